[hw/rtl/pmee_pkg.sv]
package pmee_pkg;

    localparam int DEFAULT_SIGN_STACK_DEPTH = 64;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic SIGN_PLUS  = 1'b0;
    localparam logic SIGN_MINUS = 1'b1;

    typedef logic [7:0]  t_char;
    typedef logic [31:0] t_word;

    function automatic t_word times_ten_plus(input t_word n, input t_char ch);
        t_char d;
        d = ch - CH_ZERO;
        return (n << 3) + (n << 1) + {28'd0, d[3:0]};
    endfunction

    function automatic t_word fold(input t_word total, input t_word n, input logic sign);
        return (sign == SIGN_MINUS) ? total - n : total + n;
    endfunction

endpackage

[hw/rtl/plus_minus_expression_evaluator.sv]
// Evaluates a '+'/'-' expression with parentheses, one ASCII byte per request and one
// request per clock cycle with no gaps between bytes or between expressions. Digits build
// a decimal number modulo 2^32; any other byte folds it into the total, '+'/'-' pick the
// sign from the top of the parenthesis sign stack, '(' pushes and ')' pops it. Bytes
// other than digits, operators and parentheses act as spaces. The request marked last
// produces one result (32-bit wrapping total and a nesting error flag) in the next cycle
// and restarts the evaluator. The sign stack lives in a registered-read RAM of
// SIGN_STACK_DEPTH entries; the top of stack is held in a register and the entry below
// it is read ahead every cycle, so a pop needs no wait. Nesting past the stack depth or
// an unmatched ')' sets the flag until the end of the expression. The input stalls only
// while a result waits in the output register and the output side stalls.
module plus_minus_expression_evaluator
    import pmee_pkg::*;
#(
    parameter int SIGN_STACK_DEPTH = DEFAULT_SIGN_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_value,
    output logic        o_nesting_error
);

    localparam int LW = $clog2(SIGN_STACK_DEPTH + 1);
    localparam int AW = $clog2(SIGN_STACK_DEPTH);

    logic              r_sign_stack [SIGN_STACK_DEPTH];
    logic              r_below;
    logic [LW-1:0]     r_level,   n_level;
    logic              r_top,     n_top;
    logic              r_sign,    n_sign;
    t_word             r_pending, n_pending;
    t_word             r_total,   n_total;
    logic              r_error,   n_error;
    logic              r_out_valid;
    t_word             r_out_value;
    logic              r_out_error;

    logic              accept;
    logic              is_digit;
    logic              push_ok;
    logic              pop_ok;
    logic              do_push;
    t_word             digit_pending;
    t_word             folded_total;
    t_word             final_total;
    logic [AW-1:0]     rd_addr;
    logic [LW-1:0]     below_level;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign is_digit      = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
    assign push_ok       = r_level < LW'(SIGN_STACK_DEPTH);
    assign pop_ok        = r_level > LW'(1);
    assign digit_pending = times_ten_plus(r_pending, i_character);
    assign folded_total  = fold(r_total, r_pending, r_sign);
    assign final_total   = is_digit ? fold(r_total, digit_pending, r_sign) : folded_total;
    assign do_push       = accept && !is_digit && (i_character == CH_OPEN) && push_ok;

    always_comb begin
        n_level   = r_level;
        n_top     = r_top;
        n_sign    = r_sign;
        n_pending = r_pending;
        n_total   = r_total;
        n_error   = r_error;
        if (accept) begin
            if (is_digit) begin
                n_pending = digit_pending;
            end else begin
                n_pending = '0;
                n_total   = folded_total;
                unique case (i_character)
                    CH_PLUS:  n_sign = r_top;
                    CH_MINUS: n_sign = ~r_top;
                    CH_OPEN: begin
                        if (push_ok) begin
                            n_level = r_level + LW'(1);
                            n_top   = r_sign;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    CH_CLOSE: begin
                        if (pop_ok) begin
                            n_level = r_level - LW'(1);
                            // entry zero is always plus
                            n_top   = (r_level == LW'(2)) ? SIGN_PLUS : r_below;
                        end else begin
                            n_error = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_last) begin
                n_level   = LW'(1);
                n_top     = SIGN_PLUS;
                n_sign    = SIGN_PLUS;
                n_pending = '0;
                n_total   = '0;
                n_error   = 1'b0;
            end
        end
    end

    assign below_level = n_level - LW'(2);
    assign rd_addr     = below_level[AW-1:0];

    // sign stack RAM, read ahead at the entry below the next top
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_sign_stack[r_level[AW-1:0]] <= r_sign;
        end
        r_below <= r_sign_stack[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LW'(1);
            r_top       <= SIGN_PLUS;
            r_sign      <= SIGN_PLUS;
            r_pending   <= '0;
            r_total     <= '0;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level   <= n_level;
            r_top     <= n_top;
            r_sign    <= n_sign;
            r_pending <= n_pending;
            r_total   <= n_total;
            r_error   <= n_error;
            if (accept && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_out_value <= final_total;
            r_out_error <= r_error
                        || (!is_digit && (i_character == CH_OPEN) && !push_ok)
                        || (!is_digit && (i_character == CH_CLOSE) && !pop_ok);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_value         = r_out_value;
    assign o_nesting_error = r_out_error;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level >= LW'(1)) && (r_level <= LW'(SIGN_STACK_DEPTH)))
        else $error("stack level out of range");

    a_base_plus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == LW'(1)) |-> (r_top == SIGN_PLUS))
        else $error("top of empty stack is not plus");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> o_valid)
        else $error("last request produced no result");

    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !i_last) |=> (r_level == $past(r_level) + LW'(1)))
        else $error("push did not raise stack level");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> ((r_level == LW'(1)) && !r_error && (r_total == '0)))
        else $error("evaluator not restarted after last request");

endmodule
